[rtl/pffd_pkg.sv]
package pffd_pkg;

  localparam int WORKERS_DEF = 4;
  localparam int NUM_CAPS = 4;
  localparam int CAP_W = 8;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TAG_W = 8;
  localparam int WK_W = 2;
  localparam int STATUS_W = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // classification of a queued transaction
  localparam logic [1:0] OP_RELEASE = 2'd0;
  localparam logic [1:0] OP_REJECT  = 2'd1;
  localparam logic [1:0] OP_SCAN    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RETRY      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RELEASED   = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [TAG_W-1:0] tag;
    logic [CAP_W-1:0] amount;
    logic [WK_W-1:0]  worker;
  } entry_t;

endpackage

[rtl/pffd_front.sv]
module pffd_front #(
  parameter int WORKERS = pffd_pkg::WORKERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pffd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pffd_pkg::CAP_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [pffd_pkg::TAG_W-1:0]     tag,
  input  logic [pffd_pkg::CAP_W-1:0]     amount,
  input  logic [pffd_pkg::WK_W-1:0]      worker,
  input  logic                          q_full,
  output logic                          push,
  output pffd_pkg::entry_t              push_entry
);
  import pffd_pkg::*;

  logic [CAP_W-1:0] caps [NUM_CAPS];
  logic [CAP_W-1:0] max_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_CAPS; w++) caps[w] <= '0;
    end else if (cfg_we) begin
      caps[cfg_index] <= cfg_data;
    end
  end

  // largest budget over the workers that exist
  always_comb begin
    max_cap = '0;
    for (int w = 0; w < NUM_CAPS; w++) begin
      if (w < WORKERS && caps[w] > max_cap) max_cap = caps[w];
    end
  end

  assign in_ready = !q_full;
  assign push = in_valid && in_ready;

  always_comb begin
    push_entry.tag = tag;
    push_entry.amount = amount;
    push_entry.worker = worker;
    if (req_type) push_entry.op = OP_RELEASE;
    else if (amount > max_cap) push_entry.op = OP_REJECT;
    else push_entry.op = OP_SCAN;
  end

endmodule

[rtl/pffd_queue.sv]
module pffd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pffd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output pffd_pkg::entry_t head
);
  import pffd_pkg::*;

  entry_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[rtl/pffd_back.sv]
module pffd_back #(
  parameter int WORKERS = pffd_pkg::WORKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pffd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pffd_pkg::CAP_W-1:0]     cfg_data,
  input  logic                           head_valid,
  input  pffd_pkg::entry_t               head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pffd_pkg::STATUS_W-1:0]  status,
  output logic [pffd_pkg::WK_W-1:0]      chosen_worker,
  output logic [pffd_pkg::TAG_W-1:0]     tag_out,
  output logic [pffd_pkg::CAP_W-1:0]     free_after,
  output logic [pffd_pkg::CNT_W-1:0]     rejected_total,
  output logic [pffd_pkg::CNT_W-1:0]     retry_total
);
  import pffd_pkg::*;

  localparam int WIDX = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam logic [WIDX-1:0] TOP_IDX = WIDX'(WORKERS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       op;
  logic [TAG_W-1:0] tag_r;
  logic [CAP_W-1:0] amount_r;
  logic [WK_W-1:0]  worker_r;
  logic             present;
  logic             hit;
  logic [WIDX-1:0]  idx;
  logic [CAP_W-1:0] free_res [WORKERS];

  logic [CAP_W-1:0] free_rd;
  logic [CAP_W:0]   sum;
  logic [CAP_W-1:0] sum_sat;
  logic [CAP_W-1:0] diff;
  logic             fits;
  logic             load;
  logic             head_present;
  logic [3:0]       head_wk_wide;
  logic [3:0]       cfg_wide;
  logic [3:0]       idx_wide;

  assign free_rd = free_res[idx];
  assign sum = {1'b0, free_rd} + {1'b0, amount_r};
  assign sum_sat = sum[CAP_W] ? '1 : sum[CAP_W-1:0];
  assign diff = free_rd - amount_r;
  assign fits = (free_rd >= amount_r);
  assign load = (state == ST_DONE) && (!out_valid || out_ready);
  assign pop = (state == ST_IDLE) && head_valid;

  assign head_wk_wide = 4'(head.worker);
  assign head_present = (32'(head.worker) < WORKERS);
  assign cfg_wide = 4'(cfg_index);
  assign idx_wide = 4'(idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      rejected_total <= '0;
      retry_total <= '0;
      for (int w = 0; w < WORKERS; w++) free_res[w] <= '0;
    end else begin
      if (cfg_we && 32'(cfg_index) < WORKERS) free_res[cfg_wide[WIDX-1:0]] <= cfg_data;

      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            op <= head.op;
            tag_r <= head.tag;
            amount_r <= head.amount;
            worker_r <= head.worker;
            present <= head_present;
            hit <= 1'b0;
            // release targets the named worker, a scan starts at the top
            if (head.op == OP_RELEASE) begin
              idx <= head_present ? head_wk_wide[WIDX-1:0] : '0;
              state <= ST_DONE;
            end else if (head.op == OP_SCAN) begin
              idx <= TOP_IDX;
              state <= ST_SCAN;
            end else begin
              idx <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (fits) begin
            hit <= 1'b1;
            state <= ST_DONE;
          end else if (idx == '0) begin
            state <= ST_DONE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        ST_DONE: begin
          if (load) begin
            tag_out <= tag_r;
            state <= ST_IDLE;
            case (op)
              OP_RELEASE: begin
                status <= STATUS_RELEASED;
                chosen_worker <= worker_r;
                free_after <= present ? sum_sat : '0;
                if (present) free_res[idx] <= sum_sat;
              end
              OP_REJECT: begin
                status <= STATUS_REJECTED;
                chosen_worker <= '0;
                free_after <= '0;
                if (rejected_total != '1) rejected_total <= rejected_total + 1'b1;
              end
              default: begin
                if (hit) begin
                  status <= STATUS_DISPATCHED;
                  chosen_worker <= idx_wide[WK_W-1:0];
                  free_after <= diff;
                  free_res[idx] <= diff;
                end else begin
                  status <= STATUS_RETRY;
                  chosen_worker <= '0;
                  free_after <= '0;
                  if (retry_total != '1) retry_total <= retry_total + 1'b1;
                end
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_scan_only_requests: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> op == OP_SCAN)
    else $error("scan running on a non-request transaction");

  a_scan_index_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= TOP_IDX)
    else $error("scan index beyond the last worker");

  a_counters_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> rejected_total >= $past(rejected_total) && retry_total >= $past(retry_total))
    else $error("saturating counter went down");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the completion step");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != ST_IDLE)
    else $error("popped transaction not taken into work");

endmodule

[rtl/priority_first_fit_dispatcher.sv]
// Dispatcher that places resource requests on WORKERS workers, highest index first.
// A front end classifies each transaction against the largest configured capacity
// and pushes it into a two-entry queue; the back end checks one worker budget per
// cycle with a single comparator and then updates the budget and counters. A
// completion or a rejected request passes through the pop and finish steps of the back end;
// a request that scans workers also spends a scan step on each of them, at most WORKERS. An
// accepted transaction is registered in the queue before the back end pops it, and a result
// that is not taken holds the back end in its finish step.
// Capacity writes also reload that worker's free budget and must be made while idle.
// rejected_total and retry_total saturate at 65535.
module priority_first_fit_dispatcher #(
  parameter int WORKERS = pffd_pkg::WORKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pffd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pffd_pkg::CAP_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [pffd_pkg::TAG_W-1:0]     tag,
  input  logic [pffd_pkg::CAP_W-1:0]     amount,
  input  logic [pffd_pkg::WK_W-1:0]      worker,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pffd_pkg::STATUS_W-1:0]  status,
  output logic [pffd_pkg::WK_W-1:0]      chosen_worker,
  output logic [pffd_pkg::TAG_W-1:0]     tag_out,
  output logic [pffd_pkg::CAP_W-1:0]     free_after,
  output logic [pffd_pkg::CNT_W-1:0]     rejected_total,
  output logic [pffd_pkg::CNT_W-1:0]     retry_total
);
  import pffd_pkg::*;

  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  pffd_front #(.WORKERS(WORKERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .tag        (tag),
    .amount     (amount),
    .worker     (worker),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pffd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  pffd_back #(.WORKERS(WORKERS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .chosen_worker  (chosen_worker),
    .tag_out        (tag_out),
    .free_after     (free_after),
    .rejected_total (rejected_total),
    .retry_total    (retry_total)
  );

endmodule

[bench/priority_first_fit_dispatcher_tb.sv]
module priority_first_fit_dispatcher_tb;
  import pffd_pkg::*;

  localparam int NUM_WORKERS = WORKERS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 270;

  localparam logic REQ_NEW = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAP_W0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_W1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_W2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_W3 = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WK_W-1:0]     chosen;
    logic [TAG_W-1:0]    tag;
    logic [CAP_W-1:0]    free_after;
    logic [CNT_W-1:0]    rejected;
    logic [CNT_W-1:0]    retries;
  } dispatch_result_t;

  typedef struct packed {
    logic [WK_W-1:0]  wk;
    logic [TAG_W-1:0] tg;
    logic [CAP_W-1:0] amt;
  } loan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_NEW;
  logic [TAG_W-1:0] tag = '0;
  logic [CAP_W-1:0] amount = '0;
  logic [WK_W-1:0] worker = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [WK_W-1:0] chosen_worker;
  logic [TAG_W-1:0] tag_out;
  logic [CAP_W-1:0] free_after;
  logic [CNT_W-1:0] rejected_total;
  logic [CNT_W-1:0] retry_total;

  // shadow of the dispatcher state
  logic [CAP_W-1:0] cap_model [NUM_CAPS];
  logic [CAP_W-1:0] budget_model [NUM_WORKERS];
  logic [CNT_W-1:0] reject_count_model;
  logic [CNT_W-1:0] retry_count_model;

  // expected results enter at the front and leave from the back
  dispatch_result_t pending_results[$];
  loan_t open_loans[$];
  loan_t bounced_requests[$];

  int error_count = 0;
  int results_checked = 0;
  int transactions_sent = 0;
  int settings_used = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int hold_left = 0;
  int ready_phase = 0;
  logic [15:0] ready_bits = 16'hffff;

  priority_first_fit_dispatcher u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .tag           (tag),
    .amount        (amount),
    .worker        (worker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .chosen_worker (chosen_worker),
    .tag_out       (tag_out),
    .free_after    (free_after),
    .rejected_total(rejected_total),
    .retry_total   (retry_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CAP_W-1:0] largest_capacity();
    logic [CAP_W-1:0] top;
    top = '0;
    for (int w = 0; w < NUM_WORKERS; w++) begin
      if (cap_model[w] > top) top = cap_model[w];
    end
    return top;
  endfunction

  function automatic dispatch_result_t predict_dispatch(logic kind, logic [TAG_W-1:0] tg,
                                                        logic [CAP_W-1:0] am,
                                                        logic [WK_W-1:0] wk);
    dispatch_result_t r;
    logic [CAP_W:0] sum;
    bit placed;
    r = '0;
    r.tag = tg;
    placed = 1'b0;
    if (kind == REQ_DONE) begin
      r.status = STATUS_RELEASED;
      r.chosen = wk;
      sum = {1'b0, budget_model[wk]} + {1'b0, am};
      budget_model[wk] = sum[CAP_W] ? {CAP_W{1'b1}} : sum[CAP_W-1:0];
      r.free_after = budget_model[wk];
    end else if (am > largest_capacity()) begin
      r.status = STATUS_REJECTED;
      if (reject_count_model != {CNT_W{1'b1}}) reject_count_model++;
    end else begin
      // highest index has priority
      for (int w = NUM_WORKERS - 1; w >= 0; w--) begin
        if (!placed && budget_model[w] >= am) begin
          budget_model[w] = budget_model[w] - am;
          r.chosen = w[WK_W-1:0];
          r.free_after = budget_model[w];
          placed = 1'b1;
        end
      end
      if (placed) begin
        r.status = STATUS_DISPATCHED;
      end else begin
        r.status = STATUS_RETRY;
        if (retry_count_model != {CNT_W{1'b1}}) retry_count_model++;
      end
    end
    r.rejected = reject_count_model;
    r.retries = retry_count_model;
    return r;
  endfunction

  function automatic logic [15:0] next_ready_pattern();
    case ($urandom_range(0, 3))
      0: return 16'hffff;
      1: return 16'($urandom);
      2: return 16'($urandom | $urandom);
      default: return 16'($urandom & $urandom);
    endcase
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] exp_v,
                                      logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // receiver: long hold-off when asked, otherwise a rotating random pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ready_bits[ready_phase];
      if (ready_phase == 15) begin
        ready_phase <= 0;
        ready_bits <= next_ready_pattern();
      end else begin
        ready_phase <= ready_phase + 1;
      end
    end
  end

  always @(posedge clk) begin
    dispatch_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0d tag %0d",
                 $time, status, tag_out);
      end else begin
        exp_r = pending_results.pop_back();
        check_field("status", CNT_W'(exp_r.status), CNT_W'(status));
        check_field("chosen_worker", CNT_W'(exp_r.chosen), CNT_W'(chosen_worker));
        check_field("tag_out", CNT_W'(exp_r.tag), CNT_W'(tag_out));
        check_field("free_after", CNT_W'(exp_r.free_after), CNT_W'(free_after));
        check_field("rejected_total", exp_r.rejected, rejected_total);
        check_field("retry_total", exp_r.retries, retry_total);
        results_checked++;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [TAG_W-1:0] tg,
                           input logic [CAP_W-1:0] am, input logic [WK_W-1:0] wk,
                           output dispatch_result_t res);
    in_valid <= 1'b1;
    req_type <= kind;
    tag <= tg;
    amount <= am;
    worker <= wk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_dispatch(kind, tg, am, wk);
    pending_results.push_front(res);
    transactions_sent++;
    status_seen[res.status]++;
    // keep track of what a well-behaved source would do next
    if (kind == REQ_NEW && res.status == STATUS_DISPATCHED && am != 0)
      open_loans.push_front('{wk: res.chosen, tg: tg, amt: am});
    if (res.status == STATUS_RETRY)
      bounced_requests.push_front('{wk: wk, tg: tg, amt: am});
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four capacity registers, which also reloads every budget
  task automatic load_capacities(input logic [CAP_W-1:0] c0, c1, c2, c3);
    logic [CAP_W-1:0] caps [NUM_CAPS];
    logic [CFG_IDX_W-1:0] regs [NUM_CAPS];
    caps = '{c0, c1, c2, c3};
    regs = '{REG_CAP_W0, REG_CAP_W1, REG_CAP_W2, REG_CAP_W3};
    in_valid <= 1'b0;
    wait_for_drain();
    for (int i = 0; i < NUM_CAPS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= caps[i];
      @(posedge clk);
      cap_model[regs[i]] = caps[i];
      budget_model[regs[i]] = caps[i];
    end
    cfg_we <= 1'b0;
    open_loans.delete();
    bounced_requests.delete();
    settings_used++;
  endtask

  task automatic test_zero_capacity();
    dispatch_result_t r;
    send_item(REQ_NEW, 8'h00, 8'd0, 2'd0, r);
    send_item(REQ_NEW, 8'hff, 8'd1, 2'd3, r);
    send_item(REQ_DONE, 8'h5a, 8'd10, 2'd2, r);
    send_item(REQ_NEW, 8'ha5, 8'd5, 2'd1, r);
    send_item(REQ_NEW, 8'h01, 8'd0, 2'd2, r);
    in_valid <= 1'b0;
  endtask

  task automatic test_priority_order();
    dispatch_result_t r;
    load_capacities(8'd255, 8'd0, 8'd100, 8'd40);
    send_item(REQ_NEW, 8'h10, 8'd255, 2'd0, r);
    send_item(REQ_NEW, 8'h11, 8'd255, 2'd0, r);
    send_item(REQ_DONE, 8'h12, 8'd255, 2'd0, r);
    send_item(REQ_DONE, 8'h13, 8'd255, 2'd0, r);
    send_item(REQ_NEW, 8'h14, 8'd40, 2'd1, r);
    send_item(REQ_NEW, 8'h15, 8'd1, 2'd2, r);
    send_item(REQ_NEW, 8'h16, 8'd0, 2'd3, r);
    send_item(REQ_DONE, 8'h17, 8'd0, 2'd1, r);
    send_item(REQ_DONE, 8'h18, 8'd200, 2'd3, r);
    send_item(REQ_NEW, 8'h19, 8'd200, 2'd0, r);
    send_item(REQ_NEW, 8'h1a, 8'd99, 2'd0, r);
    in_valid <= 1'b0;
  endtask

  task automatic test_full_capacity();
    dispatch_result_t r;
    load_capacities(8'd255, 8'd255, 8'd255, 8'd255);
    repeat (4) send_item(REQ_NEW, 8'hc3, 8'd255, 2'd0, r);
    send_item(REQ_NEW, 8'h3c, 8'd1, 2'd0, r);
    in_valid <= 1'b0;
  endtask

  function automatic logic [CAP_W-1:0] pick_request_amount(logic [CAP_W-1:0] top);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return top;
      2: return (top == 8'hff) ? top : CAP_W'($urandom_range(top + 1, 255));
      3: return CAP_W'($urandom_range(0, 255));
      4, 5: return CAP_W'($urandom_range(0, (top < 16) ? top : 16));
      default: return CAP_W'($urandom_range(0, top));
    endcase
  endfunction

  task automatic run_mixed_traffic(input int n_items);
    dispatch_result_t r;
    loan_t ln;
    int pick;
    int idx;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 && bounced_requests.size() != 0) begin
        ln = bounced_requests.pop_back();
        send_item(REQ_NEW, ln.tg, ln.amt, ln.wk, r);
      end else if (pick < 50 && open_loans.size() != 0) begin
        idx = $urandom_range(0, open_loans.size() - 1);
        ln = open_loans[idx];
        open_loans.delete(idx);
        send_item(REQ_DONE, ln.tg, ln.amt, ln.wk, r);
      end else if (pick < 58) begin
        // stray completion, often pushing a budget into saturation
        send_item(REQ_DONE, TAG_W'($urandom), CAP_W'($urandom), WK_W'($urandom), r);
      end else begin
        send_item(REQ_NEW, TAG_W'($urandom), pick_request_amount(largest_capacity()),
                  WK_W'($urandom), r);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_random_settings();
    load_capacities(8'd60, 8'd60, 8'd60, 8'd60);
    run_mixed_traffic(PHASE_ITEMS);
    load_capacities(8'd255, 8'd255, 8'd255, 8'd255);
    run_mixed_traffic(PHASE_ITEMS);
    load_capacities(8'd0, 8'd0, 8'd0, 8'd200);
    run_mixed_traffic(PHASE_ITEMS);
    load_capacities(8'd1, 8'd2, 8'd3, 8'd4);
    run_mixed_traffic(PHASE_ITEMS);
    repeat (2) begin
      load_capacities(CAP_W'($urandom), CAP_W'($urandom), CAP_W'($urandom),
                      CAP_W'($urandom));
      run_mixed_traffic(PHASE_ITEMS);
    end
  endtask

  task automatic test_backpressure();
    wait_for_drain();
    hold_left = HOLD_OFF_CYCLES;
    burst_left = 40;
    run_mixed_traffic(24);
  endtask

  initial begin
    for (int w = 0; w < NUM_WORKERS; w++) begin
      cap_model[w] = '0;
      budget_model[w] = '0;
    end
    reject_count_model = '0;
    retry_count_model = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_capacity();
    test_priority_order();
    test_full_capacity();
    test_random_settings();
    test_backpressure();

    wait_for_drain();
    $display("covered %0d transactions over %0d capacity settings: %0d dispatched, %0d rejected,",
             transactions_sent, settings_used + 1, status_seen[STATUS_DISPATCHED],
             status_seen[STATUS_REJECTED]);
    $display("%0d retried, %0d released; %0d results checked, %0d mismatches",
             status_seen[STATUS_RETRY], status_seen[STATUS_RELEASED], results_checked,
             error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
